// ----- hdl/ifls_pkg.sv -----
// shared constants, codes and types of the indexed free list stack
package ifls_pkg;

	localparam int OP_W      = 2;
	localparam int INDEX_W   = 10;
	localparam int COUNT_W   = 11;
	localparam int SIZE_W    = 16;
	localparam int BASE_W    = 32;
	localparam int ADDR_W    = 33;
	localparam int CHANGE_W  = 32;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 80;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_INIT = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ELEMENT_COUNT = 2'd0,
		REG_POPULATE      = 2'd1,
		REG_BASE_ADDRESS  = 2'd2,
		REG_ELEMENT_SIZE  = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_POP  = 4'b0100,
		S_INIT = 4'b1000
	} state_t;

	typedef struct packed {
		logic [CHANGE_W-1:0] change_count;
		logic [ADDR_W-1:0]   popped_address;
		logic [INDEX_W-1:0]  popped_index;
		status_t             status;
	} result_t;

endpackage

// ----- hdl/ifls_link_mem.sv -----
// next-link memory: one write port, one read port with registered read data
module ifls_link_mem import ifls_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/ifls_addr_gen.sv -----
// element address: registered index times size, then base added
module ifls_addr_gen import ifls_pkg::*; #(
	parameter int KW = 10
) (
	input  logic              clk,
	input  logic              load,
	input  logic [KW-1:0]     k,
	input  logic [SIZE_W-1:0] element_size,
	input  logic [BASE_W-1:0] base_address,
	output logic [ADDR_W-1:0] address
);

	localparam int PW = KW + SIZE_W;

	logic [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_q <= PW'(k) * PW'(element_size);
		end
	end

	// sum kept to 33 bits
	always_comb begin
		logic [PW+BASE_W-1:0] sum;
		sum = (PW+BASE_W)'(base_address) + (PW+BASE_W)'(prod_q);
		address = sum[ADDR_W-1:0];
	end

endmodule

// ----- hdl/indexed_free_list_stack.sv -----
// LIFO free list of elements linked through a next-link memory; items are taken one at a time, a
// push going from the execute state back to idle, a pop through the execute and pop states (the
// top's link is read from the memory with registered read data), and an init through the execute
// state and, with populate, a sweep that writes one link per cycle through the single write port;
// the finishing step waits while the output register is full and not taken, the result is loaded
// into it as the block returns to idle, and an item is taken while the previous result still waits.
module indexed_free_list_stack import ifls_pkg::*; #(
	parameter int MAX_ELEMENTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // operation[1:0], element_index[11:2]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // status[1:0], popped_index[11:2],
	                                         // popped_address[44:12], change_count[76:45]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int ID_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int CW    = (ID_W > COUNT_W) ? ID_W : COUNT_W;

	// configuration
	logic [COUNT_W-1:0] element_count_q;
	logic               populate_q;
	logic [BASE_W-1:0]  base_address_q;
	logic [SIZE_W-1:0]  element_size_q;

	state_t              state_q;
	logic [ID_W-1:0]     top_q;
	logic [CHANGE_W-1:0] change_q;
	logic [IDX_W-1:0]    sweep_q;
	logic                m_tvalid_q;

	op_t                   op_q;
	logic [INDEX_W-1:0]    idx_q;
	logic [IDX_W-1:0]      k_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [ID_W-1:0]   n;
	logic              in_range;
	logic [IDX_W-1:0]  top_k;
	logic              out_free;
	logic              fin;
	logic              sweep_last;
	result_t           res;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [ID_W-1:0]   mem_wdata;
	logic              mem_re;
	logic [ID_W-1:0]   mem_rdata;
	logic [ADDR_W-1:0] pop_addr;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	// element count saturated at capacity
	always_comb begin
		logic [CW-1:0] cnt_w;
		cnt_w = CW'(element_count_q);
		if (cnt_w > CW'(MAX_ELEMENTS)) begin
			n = ID_W'(MAX_ELEMENTS);
		end else begin
			n = cnt_w[ID_W-1:0];
		end
	end

	assign in_range   = CW'(idx_q) < CW'(n);
	assign top_k      = IDX_W'(top_q - ID_W'(1));
	assign sweep_last = ID_W'(sweep_q) == (n - ID_W'(1));

	ifls_link_mem #(
		.DEPTH (MAX_ELEMENTS),
		.AW    (IDX_W),
		.DW    (ID_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (top_k),
		.rdata (mem_rdata)
	);

	ifls_addr_gen #(
		.KW (IDX_W)
	) u_addr (
		.clk          (clk),
		.load         (mem_re),
		.k            (top_k),
		.element_size (element_size_q),
		.base_address (base_address_q),
		.address      (pop_addr)
	);

	// memory accesses and result of the finishing step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		fin       = 1'b0;
		res       = '0;
		res.change_count = change_q;
		unique case (state_q)
			S_IDLE: begin
			end
			S_EXEC: begin
				unique case (op_q)
					OP_PUSH: begin
						fin = 1'b1;
						if (in_range) begin
							mem_we           = out_free;
							mem_waddr        = IDX_W'(idx_q);
							mem_wdata        = top_q;
							res.change_count = change_q + CHANGE_W'(1);
						end else begin
							res.status = ST_RANGE;
						end
					end
					OP_POP: begin
						if (top_q != '0) begin
							mem_re = 1'b1;
						end else begin
							fin        = 1'b1;
							res.status = ST_EMPTY;
						end
					end
					OP_INIT: begin
						res.change_count = '0;
						fin = !(populate_q && (n != '0));
					end
					OP_NONE: begin
						fin = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			S_POP: begin
				// popped entry's link is cleared
				mem_we             = out_free;
				mem_waddr          = k_q;
				mem_wdata          = '0;
				fin                = 1'b1;
				res.popped_index   = INDEX_W'(k_q);
				res.popped_address = pop_addr;
				res.change_count   = change_q + CHANGE_W'(1);
			end
			S_INIT: begin
				// element i links to id i, so pops return the highest index first
				mem_we           = 1'b1;
				mem_waddr        = sweep_q;
				mem_wdata        = ID_W'(sweep_q);
				fin              = sweep_last;
				res.change_count = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			element_count_q <= COUNT_W'(1024);
			populate_q      <= 1'b1;
			base_address_q  <= '0;
			element_size_q  <= SIZE_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ELEMENT_COUNT: element_count_q <= cfg_data[COUNT_W-1:0];
				REG_POPULATE:      populate_q      <= cfg_data[0];
				REG_BASE_ADDRESS:  base_address_q  <= cfg_data[BASE_W-1:0];
				REG_ELEMENT_SIZE:  element_size_q  <= cfg_data[SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			top_q      <= '0;
			change_q   <= '0;
			sweep_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (fin && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (op_q == OP_POP && top_q != '0) begin
						state_q <= S_POP;
					end else if (op_q == OP_INIT && populate_q && n != '0) begin
						top_q    <= '0;
						change_q <= '0;
						sweep_q  <= '0;
						state_q  <= S_INIT;
					end else if (out_free) begin
						state_q <= S_IDLE;
						if (op_q == OP_PUSH && in_range) begin
							top_q    <= ID_W'(IDX_W'(idx_q)) + ID_W'(1);
							change_q <= change_q + CHANGE_W'(1);
						end else if (op_q == OP_INIT) begin
							top_q    <= '0;
							change_q <= '0;
						end
					end
				end
				S_POP: begin
					if (out_free) begin
						top_q    <= mem_rdata;
						change_q <= change_q + CHANGE_W'(1);
						state_q  <= S_IDLE;
					end
				end
				S_INIT: begin
					if (sweep_last) begin
						if (out_free) begin
							top_q   <= n;
							state_q <= S_IDLE;
						end
					end else begin
						sweep_q <= sweep_q + IDX_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q  <= op_t'(s_tdata[OP_W-1:0]);
			idx_q <= s_tdata[OP_W+INDEX_W-1:OP_W];
		end
		if (mem_re) begin
			k_q <= top_k;
		end
		if (fin && out_free) begin
			m_tdata_q <= OUT_DATA_W'(res);
		end
	end

`ifndef ASSERT_OFF
	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(top_q) <= CW'(MAX_ELEMENTS))
		else $error("top id beyond capacity");

	a_change_step: assert property (@(posedge clk) disable iff (!arst_n)
		(change_q != $past(change_q)) |->
			(change_q == $past(change_q) + CHANGE_W'(1)) || (change_q == '0))
		else $error("change counter moved by other than one");

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_EXEC))
		else $error("accepted word not executed");
`endif

endmodule
